FILE: rtl/core/smm_pkg.sv
// smm_pkg: shared types, codes and constants for the square matrix multiplier.
// Used by every module in rtl/core except smm_ram; depends on nothing.
package smm_pkg;

  localparam int MAX_DIM_DEFAULT = 8;
  localparam int IDX_W           = 3;
  localparam int VAL_W           = 16;
  localparam int SIZE_W          = 4;
  localparam int CMD_Q_DEPTH     = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // input operation codes
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_MULT   = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_MULT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic [VAL_W-1:0]    value;
    logic [SIZE_W-1:0]   size;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_MULT
  } back_state_t;

endpackage

FILE: rtl/core/smm_ram.sv
// smm_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/smm_front.sv
// smm_front: accepts input items, holds the matrix size register and classifies
// items into commands for the queue. Depends on smm_pkg.
module smm_front import smm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SIZE_W-1:0]       cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              operation,
  input  logic [IDX_W-1:0]        row_index,
  input  logic [IDX_W-1:0]        column_index,
  input  logic signed [VAL_W-1:0] element_value,
  output logic                    q_push,
  output cmd_t                    q_cmd,
  input  logic                    q_full
);

  logic [SIZE_W-1:0] matrix_size;
  logic [SIZE_W-1:0] eff_size;
  logic              in_range;
  logic              keep;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      matrix_size <= cfg_data;
    end
  end

  // size zero acts as one, oversize saturates
  always_comb begin
    if (matrix_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (matrix_size > SIZE_W'(MAX_DIM)) begin
      eff_size = SIZE_W'(MAX_DIM);
    end else begin
      eff_size = matrix_size;
    end
  end

  assign in_range = ({1'b0, row_index} < (IDX_W + 1)'(MAX_DIM)) &&
                    ({1'b0, column_index} < (IDX_W + 1)'(MAX_DIM));

  always_comb begin
    keep        = 1'b0;
    q_cmd.kind  = CMD_MULT;
    q_cmd.row   = row_index;
    q_cmd.col   = column_index;
    q_cmd.value = element_value;
    q_cmd.size  = eff_size;
    case (operation)
      OP_LOAD_A: begin
        keep       = in_range;
        q_cmd.kind = CMD_LOAD_A;
      end
      OP_LOAD_B: begin
        keep       = in_range;
        q_cmd.kind = CMD_LOAD_B;
      end
      OP_MULT: begin
        keep       = 1'b1;
        q_cmd.kind = CMD_MULT;
      end
      default: begin
        keep = 1'b0;  // drop unused operation
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

FILE: rtl/core/smm_cmd_queue.sv
// smm_cmd_queue: short command queue between front and back.
// Depends on smm_pkg.
module smm_cmd_queue import smm_pkg::*; #(
  parameter int DEPTH = CMD_Q_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entry [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/smm_back.sv
// smm_back: executes queued commands: writes the A and B stores, and runs the
// multiply sequencer and multiply-accumulate pipeline. Depends on smm_pkg, smm_ram.
module smm_back import smm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  cmd_t                    q_cmd,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_column,
  output logic signed [VAL_W-1:0] product_value,
  output logic                    last_element
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  back_state_t state, state_next;

  logic [IDX_W-1:0] r, c, k, n_last;
  logic             adv, issue, k_last, c_last, r_last, start;
  logic             we_a, we_b;
  logic [AW-1:0]    waddr, addr_a, addr_b;
  logic [VAL_W-1:0] rd_a, rd_b;
  logic [SIZE_W-1:0] size_m1;

  logic             s1_valid, s1_first, s1_lastk, s1_last;
  logic [IDX_W-1:0] s1_r, s1_c;
  logic             s2_valid, s2_first, s2_lastk, s2_last;
  logic [IDX_W-1:0] s2_r, s2_c;
  logic [VAL_W-1:0] s2_prod;
  logic signed [2*VAL_W-1:0] full_prod;
  logic [VAL_W-1:0] acc, sum;

  function automatic logic [AW-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                               input logic [IDX_W-1:0] col);
    return AW'(row) * AW'(MAX_DIM) + AW'(col);
  endfunction

  // freeze the whole pipeline while a result waits on a stalled output
  assign adv    = !(out_valid && out_stall);
  assign issue  = (state == BK_MULT) && adv;
  assign k_last = (k == n_last);
  assign c_last = (c == n_last);
  assign r_last = (r == n_last);
  assign start  = q_pop && (q_cmd.kind == CMD_MULT);
  assign size_m1 = q_cmd.size - SIZE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    we_a       = 1'b0;
    we_b       = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            CMD_LOAD_A: we_a = 1'b1;
            CMD_LOAD_B: we_b = 1'b1;
            CMD_MULT:   state_next = BK_MULT;
            default:    ;
          endcase
        end
      end
      BK_MULT: begin
        if (issue && k_last && c_last && r_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // row, column, inner index sequencer
  always_ff @(posedge clk) begin
    if (start) begin
      r      <= '0;
      c      <= '0;
      k      <= '0;
      n_last <= size_m1[IDX_W-1:0];
    end else if (issue) begin
      if (!k_last) begin
        k <= k + IDX_W'(1);
      end else begin
        k <= '0;
        if (!c_last) begin
          c <= c + IDX_W'(1);
        end else begin
          c <= '0;
          r <= r + IDX_W'(1);
        end
      end
    end
  end

  assign waddr  = elem_addr(q_cmd.row, q_cmd.col);
  assign addr_a = elem_addr(r, k);
  assign addr_b = elem_addr(k, c);

  smm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (q_cmd.value),
    .re    (issue),
    .raddr (addr_a),
    .rdata (rd_a)
  );

  smm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (q_cmd.value),
    .re    (issue),
    .raddr (addr_b),
    .rdata (rd_b)
  );

  assign full_prod = $signed(rd_a) * $signed(rd_b);
  assign sum       = (s2_first ? '0 : acc) + s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid && s2_lastk;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first <= (k == '0);
      s1_lastk <= k_last;
      s1_last  <= r_last && c_last;
      s1_r     <= r;
      s1_c     <= c;
      s2_first <= s1_first;
      s2_lastk <= s1_lastk;
      s2_last  <= s1_last;
      s2_r     <= s1_r;
      s2_c     <= s1_c;
      s2_prod  <= full_prod[VAL_W-1:0];
      if (s2_valid) begin
        acc <= sum;
      end
      if (s2_valid && s2_lastk) begin
        out_row       <= s2_r;
        out_column    <= s2_c;
        product_value <= $signed(sum);
        last_element  <= s2_last;
      end
    end
  end

endmodule

FILE: rtl/core/square_matrix_multiply_int16_top.sv
// square_matrix_multiply_int16_top: n x n signed 16-bit matrix multiply, C = A * B.
// Loads: one per cycle while in_stall is low; each is queued, then written to its store.
// Multiply: n*n*n steps of the single multiply-accumulate unit, one inner-product
//   step per cycle unless out_stall holds it, through registered read, product and sum.
// Reset (rst, synchronous): clears queue, pipeline and output; matrix_size -> 8.
//   The A and B stores are not cleared.
//
// Depends on smm_pkg, smm_front, smm_cmd_queue, smm_back (and smm_ram below it).
module square_matrix_multiply_int16_top import smm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration: matrix_size
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SIZE_W-1:0]       cfg_data,
  // input items
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              operation,
  input  logic [IDX_W-1:0]        row_index,
  input  logic [IDX_W-1:0]        column_index,
  input  logic signed [VAL_W-1:0] element_value,
  // product elements
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_column,
  output logic signed [VAL_W-1:0] product_value,
  output logic                    last_element
);

  // Front classifies each transfer: loads outside the store and the unused
  // operation are dropped here; everything else enters the command queue
  // with the effective size attached.
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  smm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .row_index     (row_index),
    .column_index  (column_index),
    .element_value (element_value),
    .q_push        (q_push),
    .q_cmd         (push_cmd),
    .q_full        (q_full)
  );

  // The queue lets loads keep flowing while the back end is still busy;
  // input stalls only once it fills behind a running multiply.
  smm_cmd_queue #(.DEPTH(CMD_Q_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // Back end: store writes, then the r/c/k sequencer feeding RAM read,
  // multiply and accumulate stages; a stalled output freezes the pipeline.
  smm_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_cmd         (pop_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_column    (out_column),
    .product_value (product_value),
    .last_element  (last_element)
  );

  // never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  // the final element sits on the diagonal
  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_element |-> out_row == out_column)
    else $error("last element off the diagonal");

  // no result right after reset
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule
